/* hw/rtl/ssd_pkg.sv */
`timescale 1ns / 1ps

package ssd_pkg;

  // Default sizes of the stores
  localparam int DEF_MAX_WIDTH = 64;
  localparam int DEF_MAX_RANGE = 32;

  // Fixed field widths
  localparam int PIXEL_W  = 8;
  localparam int OFFSET_W = 6;
  localparam int COST_W   = 22;
  localparam int SEGW_W   = 7;
  localparam int RANGE_W  = 6;

  // Configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 7;

  localparam logic [CFG_IDX_W-1:0] REG_SEG_WIDTH    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SEARCH_RANGE = 2'd1;

  localparam logic [SEGW_W-1:0]  SEG_WIDTH_RST    = 7'd16;
  localparam logic [RANGE_W-1:0] SEARCH_RANGE_RST = 6'd5;

  // Pixel modes
  localparam logic MODE_REF = 1'b0;
  localparam logic MODE_WIN = 1'b1;

  // Largest squared difference of two pixels needs 16 bits
  localparam int SQ_W = 16;

  typedef enum logic [1:0] {
    S_IDLE,
    S_RUN,
    S_FLUSH,
    S_DONE
  } srch_state_e;

  typedef struct packed {
    logic busy;
    logic done;
  } srch_status_t;

endpackage

/* hw/rtl/ssd_ram.sv */
`timescale 1ns / 1ps

module ssd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* hw/rtl/ssd_search.sv */
`timescale 1ns / 1ps

module ssd_search #(
  parameter int MAX_WIDTH = ssd_pkg::DEF_MAX_WIDTH,
  parameter int MAX_RANGE = ssd_pkg::DEF_MAX_RANGE,
  parameter int WIN_DEPTH = MAX_WIDTH + 2 * MAX_RANGE - 1,
  parameter int IW        = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1,
  parameter int KW        = $clog2(2 * MAX_RANGE),
  parameter int WA_W      = $clog2(WIN_DEPTH),
  parameter int CW        = $clog2(MAX_WIDTH * 65025 + 1)
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start_i,
  input  logic                            ack_i,
  input  logic [IW-1:0]                   w_m1_i,
  input  logic [KW-1:0]                   k_m1_i,
  output logic [IW-1:0]                   ref_addr_o,
  input  logic [ssd_pkg::PIXEL_W-1:0]     ref_data_i,
  output logic [WA_W-1:0]                 win_addr_o,
  input  logic [ssd_pkg::PIXEL_W-1:0]     win_data_i,
  output ssd_pkg::srch_status_t           status_o,
  output logic [KW-1:0]                   best_k_o,
  output logic [CW-1:0]                   best_cost_o
);

  import ssd_pkg::*;

  srch_state_e state_q, state_d;
  logic [IW-1:0] i_q, i_d;
  logic [KW-1:0] k_q, k_d;
  logic          issue;

  // Stage 1: read in flight
  logic          p1_valid_q, p1_first_q, p1_end_q, p1_lastk_q;
  logic [KW-1:0] p1_k_q;
  // Stage 2: squared difference
  logic            p2_valid_q, p2_first_q, p2_end_q, p2_lastk_q;
  logic [KW-1:0]   p2_k_q;
  logic [SQ_W-1:0] sq_q;
  // Stage 3: accumulate and compare
  logic [CW-1:0] acc_q, sum;
  logic [CW-1:0] best_cost_q;
  logic [KW-1:0] best_k_q;
  logic          fin_q;

  logic signed [PIXEL_W:0]     diff;
  logic signed [2*PIXEL_W+1:0] prod;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      i_q     <= '0;
      k_q     <= '0;
    end else begin
      state_q <= state_d;
      i_q     <= i_d;
      k_q     <= k_d;
    end
  end

  always_comb begin
    state_d = state_q;
    i_d     = i_q;
    k_d     = k_q;
    issue   = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          i_d     = '0;
          k_d     = '0;
          state_d = S_RUN;
        end
      end
      S_RUN: begin
        issue = 1'b1;
        if (i_q == w_m1_i) begin
          i_d = '0;
          if (k_q == k_m1_i) begin
            state_d = S_FLUSH;
          end else begin
            k_d = k_q + 1'b1;
          end
        end else begin
          i_d = i_q + 1'b1;
        end
      end
      S_FLUSH: begin
        if (fin_q) begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (ack_i) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign ref_addr_o = i_q;
  assign win_addr_o = WA_W'(k_q) + WA_W'(i_q);

  // Valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p1_valid_q <= 1'b0;
      p2_valid_q <= 1'b0;
      fin_q      <= 1'b0;
    end else begin
      p1_valid_q <= issue;
      p2_valid_q <= p1_valid_q;
      fin_q      <= p2_valid_q && p2_end_q && p2_lastk_q;
    end
  end

  assign diff = $signed({1'b0, ref_data_i}) - $signed({1'b0, win_data_i});
  assign prod = diff * diff;
  assign sum  = (p2_first_q ? '0 : acc_q) + CW'(sq_q);

  always_ff @(posedge clk_i) begin
    p1_first_q <= (i_q == '0);
    p1_end_q   <= (i_q == w_m1_i);
    p1_lastk_q <= (k_q == k_m1_i);
    p1_k_q     <= k_q;

    p2_first_q <= p1_first_q;
    p2_end_q   <= p1_end_q;
    p2_lastk_q <= p1_lastk_q;
    p2_k_q     <= p1_k_q;
    sq_q       <= prod[SQ_W-1:0];

    if (p2_valid_q) begin
      acc_q <= sum;
      // Keep the first offset on ties
      if (p2_end_q && (p2_k_q == '0 || sum < best_cost_q)) begin
        best_cost_q <= sum;
        best_k_q    <= p2_k_q;
      end
    end
  end

  assign status_o.busy = (state_q != S_IDLE);
  assign status_o.done = (state_q == S_DONE);
  assign best_k_o      = best_k_q;
  assign best_cost_o   = best_cost_q;

  a_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> state_q == S_IDLE)
    else $error("search started while busy");

  a_addr_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_RUN |-> int'(win_addr_o) < WIN_DEPTH)
    else $error("window read beyond store");

  a_fin_flush: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fin_q |-> state_q == S_FLUSH)
    else $error("final sum outside flush");

  a_pipe_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    issue |=> p1_valid_q ##1 p2_valid_q)
    else $error("pipeline lost a read");

endmodule

/* hw/rtl/ssd_window_search.sv */
`timescale 1ns / 1ps
// Channel   Direction  Handshake              Payload
// in        sink       in_valid_i/in_stall_o  in_mode_i, in_pixel_i, in_last_i
// out       source     out_valid_o/out_stall_i out_best_offset_o, out_min_cost_o, out_status_o
// cfg       sink       cfg_valid_i/cfg_ready_o cfg_index_i, cfg_data_i
//
// A window pixel with last that closes a full window starts the search: memory
// reads over every offset and position (one reference and one window read per
// cycle), then a drain of the square/accumulate pipeline, then the result moves
// to the output register.
// Reset clears the counters and the output valid and loads the configuration
// reset values; the pixel stores hold garbage until written. Input stalls through
// the search, and a closing window pixel stalls while a held result cannot leave.

module ssd_window_search #(
  parameter int MAX_WIDTH = ssd_pkg::DEF_MAX_WIDTH,
  parameter int MAX_RANGE = ssd_pkg::DEF_MAX_RANGE
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // Pixel stream
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic                           in_mode_i,
  input  logic [ssd_pkg::PIXEL_W-1:0]    in_pixel_i,
  input  logic                           in_last_i,
  // Result stream
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [ssd_pkg::OFFSET_W-1:0]   out_best_offset_o,
  output logic [ssd_pkg::COST_W-1:0]     out_min_cost_o,
  output logic                           out_status_o,
  // Register writes
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [ssd_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [ssd_pkg::CFG_DATA_W-1:0] cfg_data_i
);

  import ssd_pkg::*;

  localparam int WIN_DEPTH = MAX_WIDTH + 2 * MAX_RANGE - 1;
  localparam int RA_W      = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int RC_W      = $clog2(MAX_WIDTH + 1);
  localparam int WA_W      = $clog2(WIN_DEPTH);
  localparam int WC_W      = $clog2(WIN_DEPTH + 1);
  localparam int KW        = $clog2(2 * MAX_RANGE);
  localparam int WCL_W     = $clog2(MAX_WIDTH + 1);
  localparam int RCL_W     = $clog2(MAX_RANGE + 1);
  localparam int CW        = $clog2(MAX_WIDTH * 65025 + 1);

  // Configuration
  logic [SEGW_W-1:0]  seg_width_q;
  logic [RANGE_W-1:0] search_range_q;

  // Loader state
  logic [RC_W-1:0] ref_cnt_q, ref_cnt_d, ref_base;
  logic            ref_closed_q;
  logic [WC_W-1:0] win_cnt_q, win_cnt_d, win_cnt_inc;

  // Output register
  logic                out_valid_q;
  logic [OFFSET_W-1:0] out_offset_q;
  logic [COST_W-1:0]   out_cost_q;
  logic                out_status_q;

  logic in_xfer, ref_xfer, win_xfer, win_close;
  logic ref_we, win_we;
  logic short_win, start, out_free, ack;

  logic [WCL_W-1:0] w_c;
  logic [RCL_W-1:0] r_c;
  logic [RCL_W:0]   two_r;
  logic [WC_W-1:0]  need;
  logic [RA_W-1:0]  w_m1;
  logic [KW-1:0]    k_m1;

  logic [RA_W-1:0]    ref_raddr;
  logic [WA_W-1:0]    win_raddr;
  logic [PIXEL_W-1:0] ref_rdata, win_rdata;
  srch_status_t       srch_st;
  logic [KW-1:0]      best_k;
  logic [CW-1:0]      best_cost;
  logic [KW+OFFSET_W-1:0] best_k_ext;
  logic [CW+COST_W-1:0]   best_cost_ext;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seg_width_q    <= SEG_WIDTH_RST;
      search_range_q <= SEARCH_RANGE_RST;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_SEG_WIDTH:    seg_width_q    <= cfg_data_i[SEGW_W-1:0];
        REG_SEARCH_RANGE: search_range_q <= cfg_data_i[RANGE_W-1:0];
        default: ;
      endcase
    end
  end

  // Saturate the registers into their legal ranges
  always_comb begin
    if (seg_width_q == '0) begin
      w_c = WCL_W'(1);
    end else if (int'(seg_width_q) > MAX_WIDTH) begin
      w_c = WCL_W'(MAX_WIDTH);
    end else begin
      w_c = WCL_W'(seg_width_q);
    end
    if (search_range_q == '0) begin
      r_c = RCL_W'(1);
    end else if (int'(search_range_q) > MAX_RANGE) begin
      r_c = RCL_W'(MAX_RANGE);
    end else begin
      r_c = RCL_W'(search_range_q);
    end
  end

  assign two_r = {r_c, 1'b0};
  assign need  = WC_W'(w_c) + WC_W'(two_r) - WC_W'(1);
  assign w_m1  = RA_W'(w_c - WCL_W'(1));
  assign k_m1  = KW'(two_r - (RCL_W + 1)'(1));

  // Hold the closing window pixel while an earlier result still sits
  // stalled in the output register; hold everything during the search.
  assign in_stall_o = srch_st.busy ||
                      (in_mode_i == MODE_WIN && in_last_i && out_valid_q && out_stall_i);

  assign in_xfer   = in_valid_i && !in_stall_o;
  assign ref_xfer  = in_xfer && (in_mode_i == MODE_REF);
  assign win_xfer  = in_xfer && (in_mode_i == MODE_WIN);
  assign win_close = win_xfer && in_last_i;

  // Reference run: restart at zero after a closed run, drop overflow
  assign ref_base  = ref_closed_q ? '0 : ref_cnt_q;
  assign ref_we    = ref_xfer && (int'(ref_base) < MAX_WIDTH);
  assign ref_cnt_d = ref_we ? ref_base + 1'b1 : ref_base;

  // Window run: drop pixels past the store depth
  assign win_we      = win_xfer && (int'(win_cnt_q) < WIN_DEPTH);
  assign win_cnt_inc = win_we ? win_cnt_q + 1'b1 : win_cnt_q;
  assign win_cnt_d   = in_last_i ? '0 : win_cnt_inc;
  assign short_win   = win_cnt_inc < need;

  assign start = win_close && !short_win;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ref_cnt_q    <= '0;
      ref_closed_q <= 1'b0;
      win_cnt_q    <= '0;
    end else begin
      if (ref_xfer) begin
        ref_cnt_q    <= ref_cnt_d;
        ref_closed_q <= in_last_i;
      end
      if (win_xfer) begin
        win_cnt_q <= win_cnt_d;
      end
    end
  end

  ssd_ram #(
    .WIDTH (PIXEL_W),
    .DEPTH (MAX_WIDTH),
    .AW    (RA_W)
  ) u_ref_ram (
    .clk_i   (clk_i),
    .we_i    (ref_we),
    .waddr_i (ref_base[RA_W-1:0]),
    .wdata_i (in_pixel_i),
    .raddr_i (ref_raddr),
    .rdata_o (ref_rdata)
  );

  ssd_ram #(
    .WIDTH (PIXEL_W),
    .DEPTH (WIN_DEPTH),
    .AW    (WA_W)
  ) u_win_ram (
    .clk_i   (clk_i),
    .we_i    (win_we),
    .waddr_i (win_cnt_q[WA_W-1:0]),
    .wdata_i (in_pixel_i),
    .raddr_i (win_raddr),
    .rdata_o (win_rdata)
  );

  ssd_search #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_RANGE (MAX_RANGE),
    .WIN_DEPTH (WIN_DEPTH),
    .IW        (RA_W),
    .KW        (KW),
    .WA_W      (WA_W),
    .CW        (CW)
  ) u_search (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start),
    .ack_i       (ack),
    .w_m1_i      (w_m1),
    .k_m1_i      (k_m1),
    .ref_addr_o  (ref_raddr),
    .ref_data_i  (ref_rdata),
    .win_addr_o  (win_raddr),
    .win_data_i  (win_rdata),
    .status_o    (srch_st),
    .best_k_o    (best_k),
    .best_cost_o (best_cost)
  );

  // Output register: free when empty or draining this cycle
  assign out_free = !out_valid_q || !out_stall_i;
  assign ack      = srch_st.done && out_free;

  assign best_k_ext    = {{OFFSET_W{1'b0}}, best_k};
  assign best_cost_ext = {{COST_W{1'b0}}, best_cost};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ack || (win_close && short_win)) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ack) begin
      out_offset_q <= best_k_ext[OFFSET_W-1:0];
      out_cost_q   <= best_cost_ext[COST_W-1:0];
      out_status_q <= 1'b0;
    end else if (win_close && short_win) begin
      // Short window: report the fault with zero offset and sum
      out_offset_q <= '0;
      out_cost_q   <= '0;
      out_status_q <= 1'b1;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign out_best_offset_o = out_offset_q;
  assign out_min_cost_o    = out_cost_q;
  assign out_status_o      = out_status_q;

endmodule

/* sim/tb_ssd_window_search.sv */
`timescale 1ns / 1ps

module tb_ssd_window_search;
  import ssd_pkg::*;

  localparam int MAX_WIDTH = DEF_MAX_WIDTH;
  localparam int MAX_RANGE = DEF_MAX_RANGE;
  localparam int WIN_DEPTH = MAX_WIDTH + 2 * MAX_RANGE - 1;

  // Index with no register behind it; writes to it must leave both registers alone
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

  localparam int N_PHASES       = 10;
  localparam int PHASE_ITEMS    = 180;
  localparam int SETTLE_CYCLES  = 8;
  // Longest search is 2R*W reads plus the pipeline drain
  localparam int DRAIN_CYCLES   = 2 * MAX_RANGE * MAX_WIDTH + 100;
  localparam int WATCHDOG_LIMIT = 20000;

  // Content patterns for generated runs
  localparam int PAT_RANDOM = 0;
  localparam int PAT_SMALL  = 1;
  localparam int PAT_HIGH   = 2;
  localparam int PAT_LOW    = 3;
  localparam int PAT_EMBED  = 4;

  typedef struct packed {
    logic                 mode;
    logic [PIXEL_W-1:0]   pixel;
    logic                 last;
    logic                 hold;   // wait until every expected match has arrived
  } pix_item_t;

  typedef struct packed {
    logic [OFFSET_W-1:0]  best_offset;
    logic [COST_W-1:0]    min_cost;
    logic                 status;
  } match_t;

  // Clock, reset and block inputs, all known from time zero
  logic                  clk_i       = 1'b0;
  logic                  rst_ni      = 1'b0;
  logic                  in_valid    = 1'b0;
  logic                  in_mode     = MODE_REF;
  logic [PIXEL_W-1:0]    in_pixel    = '0;
  logic                  in_last     = 1'b0;
  logic                  out_stall   = 1'b0;
  logic                  cfg_valid   = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index   = REG_SEG_WIDTH;
  logic [CFG_DATA_W-1:0] cfg_data    = '0;

  logic                  in_stall_o;
  logic                  out_valid_o;
  logic [OFFSET_W-1:0]   out_best_offset_o;
  logic [COST_W-1:0]     out_min_cost_o;
  logic                  out_status_o;
  logic                  cfg_ready_o;

  // Pixels waiting to be driven, and matches waiting to come out
  pix_item_t pixel_q[$];
  match_t    exp_match_q[$];

  // Predicted block state
  logic [SEGW_W-1:0]  seg_width_q    = SEG_WIDTH_RST;
  logic [RANGE_W-1:0] search_range_q = SEARCH_RANGE_RST;
  logic [PIXEL_W-1:0] ref_mem [MAX_WIDTH];
  logic [PIXEL_W-1:0] win_mem [WIN_DEPTH];
  logic [6:0]         ref_cnt    = '0;
  logic [7:0]         win_cnt    = '0;
  logic               ref_closed = 1'b0;

  // Generator bookkeeping, one step ahead of the driver
  logic [PIXEL_W-1:0] gen_ref_mem [MAX_WIDTH];
  int                 gen_ref_cnt    = 0;
  int                 gen_ref_filled = 0;
  int                 gen_win_cnt    = 0;
  logic               gen_ref_closed = 1'b0;
  int                 gen_items      = 0;

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int send_gap      = 0;
  int recv_gap      = 0;
  int fail_cnt      = 0;
  int idle_cycles   = 0;

  ssd_window_search u_dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid),
    .in_stall_o        (in_stall_o),
    .in_mode_i         (in_mode),
    .in_pixel_i        (in_pixel),
    .in_last_i         (in_last),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall),
    .out_best_offset_o (out_best_offset_o),
    .out_min_cost_o    (out_min_cost_o),
    .out_status_o      (out_status_o),
    .cfg_valid_i       (cfg_valid),
    .cfg_ready_o       (cfg_ready_o),
    .cfg_index_i       (cfg_index),
    .cfg_data_i        (cfg_data)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Segment width and search range as the block uses them: saturated to the store sizes
  function automatic int eff_width();
    if (seg_width_q < 1) return 1;
    if (seg_width_q > MAX_WIDTH) return MAX_WIDTH;
    return int'(seg_width_q);
  endfunction

  function automatic int eff_range();
    if (search_range_q < 1) return 1;
    if (search_range_q > MAX_RANGE) return MAX_RANGE;
    return int'(search_range_q);
  endfunction

  // Advance the predicted state by one accepted pixel; queue the match a closing
  // window pixel produces.
  task automatic match_pixel(input logic mode, input logic [PIXEL_W-1:0] pix,
                             input logic last);
    int     w;
    int     r;
    int     need;
    int     k;
    int     i;
    int     d;
    int     cost;
    int     best_cost;
    int     best_k;
    match_t res;
    if (mode == MODE_REF) begin
      // A reference pixel after a closed run starts a new reference
      if (ref_closed) begin
        ref_cnt    = '0;
        ref_closed = 1'b0;
      end
      // Drop pixels beyond the reference store
      if (ref_cnt < MAX_WIDTH) begin
        ref_mem[ref_cnt] = pix;
        ref_cnt++;
      end
      if (last) ref_closed = 1'b1;
    end else begin
      // Drop pixels beyond the window store
      if (win_cnt < WIN_DEPTH) begin
        win_mem[win_cnt] = pix;
        win_cnt++;
      end
      if (last) begin
        w         = eff_width();
        r         = eff_range();
        need      = w + 2 * r - 1;
        res       = '0;
        best_cost = 0;
        best_k    = 0;
        if (int'(win_cnt) < need) begin
          // Short window: flag it, offset and sum stay zero
          res.status = 1'b1;
        end else begin
          for (k = 0; k < 2 * r; k++) begin
            cost = 0;
            for (i = 0; i < w; i++) begin
              d    = int'(ref_mem[i]) - int'(win_mem[k + i]);
              cost += d * d;
            end
            // Strictly smaller only, so the lowest offset wins a tie
            if (k == 0 || cost < best_cost) begin
              best_cost = cost;
              best_k    = k;
            end
          end
          res.best_offset = best_k[OFFSET_W-1:0];
          res.min_cost    = best_cost[COST_W-1:0];
        end
        win_cnt = '0;
        exp_match_q.push_back(res);
      end
    end
  endtask

  // Queue one pixel for the driver and track what the block will have stored
  task automatic push_pixel(input logic mode, input logic [PIXEL_W-1:0] pix,
                            input logic last, input logic hold);
    int need;
    need = eff_width() + 2 * eff_range() - 1;
    if (mode == MODE_REF) begin
      if (gen_ref_closed) begin
        gen_ref_cnt    = 0;
        gen_ref_closed = 1'b0;
      end
      if (gen_ref_cnt < MAX_WIDTH) begin
        gen_ref_mem[gen_ref_cnt] = pix;
        gen_ref_cnt++;
      end
      if (gen_ref_cnt > gen_ref_filled) gen_ref_filled = gen_ref_cnt;
      if (last) gen_ref_closed = 1'b1;
    end else begin
      if (gen_win_cnt < WIN_DEPTH) gen_win_cnt++;
      // Never close a full window over reference positions that were never loaded
      if (last && gen_win_cnt >= need && gen_ref_filled < eff_width()) last = 1'b0;
      if (last) gen_win_cnt = 0;
    end
    pixel_q.push_back('{mode: mode, pixel: pix, last: last, hold: hold});
    gen_items++;
  endtask

  function automatic logic [PIXEL_W-1:0] pick_pixel(input int pat);
    case (pat)
      PAT_SMALL: begin
        return PIXEL_W'($urandom_range(0, 3));
      end
      PAT_HIGH: begin
        return '1;
      end
      PAT_LOW: begin
        return '0;
      end
      default: begin
        return PIXEL_W'($urandom_range(0, 255));
      end
    endcase
  endfunction

  // Hold the caller until every pixel went in and every match came out
  task automatic wait_drained();
    do @(posedge clk_i);
    while (pixel_q.size() != 0 || in_valid || exp_match_q.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(posedge clk_i);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk_i);
    while (!cfg_ready_o);
    // Transfer at this edge: mirror it in the predicted registers
    if (idx == REG_SEG_WIDTH) seg_width_q = val[SEGW_W-1:0];
    else if (idx == REG_SEARCH_RANGE) search_range_q = val[RANGE_W-1:0];
    cfg_valid <= 1'b0;
  endtask

  task automatic gen_ref_run();
    int len;
    int pat;
    int j;
    case ($urandom_range(0, 7))
      0: begin
        len = $urandom_range(1, eff_width());          // short reference
      end
      1: begin
        len = $urandom_range(MAX_WIDTH + 1, MAX_WIDTH + 6);  // overflow
      end
      default: begin
        len = $urandom_range(eff_width(), MAX_WIDTH);
      end
    endcase
    pat = $urandom_range(PAT_RANDOM, PAT_LOW);
    for (j = 0; j < len; j++) push_pixel(MODE_REF, pick_pixel(pat), j == len - 1, 1'b0);
  endtask

  task automatic gen_window_run();
    int   w;
    int   need;
    int   len;
    int   pat;
    int   k0;
    int   j;
    logic hold;
    logic [PIXEL_W-1:0] pix;
    w    = eff_width();
    need = w + 2 * eff_range() - 1;
    case ($urandom_range(0, 9))
      0: begin
        len = need - 1;                                 // one pixel short
      end
      1: begin
        len = $urandom_range(1, need);
      end
      2: begin
        len = $urandom_range(WIN_DEPTH + 1, WIN_DEPTH + 4);  // overflow
      end
      3, 4: begin
        len = need + $urandom_range(1, 4);
      end
      default: begin
        len = need;
      end
    endcase
    pat  = $urandom_range(PAT_RANDOM, PAT_EMBED);
    k0   = $urandom_range(0, 2 * eff_range() - 1);
    hold = ($urandom_range(0, 29) == 0);
    for (j = 0; j < len; j++) begin
      pix = pick_pixel(pat);
      // Plant the reference at one offset so that a zero-cost match exists
      if (pat == PAT_EMBED && j >= k0 && j < k0 + w) pix = gen_ref_mem[j - k0];
      push_pixel(MODE_WIN, pix, j == len - 1, hold && j == 0);
    end
  endtask

  task automatic gen_phase(input int n_items);
    int stop_at;
    int n;
    int j;
    int choice;
    stop_at = gen_items + n_items;
    // Open with the largest possible cost at this setting; this also loads all 64
    // reference positions so that no later search reads an unwritten one.
    for (j = 0; j < MAX_WIDTH; j++) push_pixel(MODE_REF, '0, j == MAX_WIDTH - 1, 1'b0);
    for (j = 0; j < eff_width() + 2 * eff_range() - 1; j++)
      push_pixel(MODE_WIN, '1, j == eff_width() + 2 * eff_range() - 2, 1'b0);
    while (gen_items < stop_at) begin
      choice = $urandom_range(0, 99);
      if (choice < 15) begin
        gen_ref_run();
      end else if (choice < 85) begin
        gen_window_run();
      end else begin
        // Noise: any mode, any pixel, stray last marks
        n = $urandom_range(1, 8);
        for (j = 0; j < n; j++)
          push_pixel(logic'($urandom_range(0, 1)), PIXEL_W'($urandom_range(0, 255)),
                     $urandom_range(0, 3) == 0, 1'b0);
      end
    end
  endtask

  // Stimulus and phase control
  initial begin
    logic [CFG_DATA_W-1:0] seg_set   [N_PHASES];
    logic [CFG_DATA_W-1:0] range_set [N_PHASES];
    int p;
    seg_set   = '{7'd16, 7'd1, 7'd64, 7'd0, 7'd127, 7'd100, 7'd5, 7'd33, 7'd0, 7'd16};
    range_set = '{7'd5,  7'd1, 7'd32, 7'd0, 7'd127, 7'd40,  7'd3, 7'd17, 7'd0, 7'd5};
    seg_set[8]   = CFG_DATA_W'($urandom_range(1, MAX_WIDTH));
    range_set[8] = CFG_DATA_W'($urandom_range(1, MAX_RANGE));

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // Short window under the reset settings
    push_pixel(MODE_WIN, 8'd255, 1'b1, 1'b0);
    wait_drained();

    // Directed part: W = 2, R = 1, so a full window holds three pixels
    write_reg(REG_SEG_WIDTH, 7'd2);
    write_reg(REG_SEARCH_RANGE, 7'd1);
    push_pixel(MODE_REF, 8'd0,   1'b0, 1'b0);
    push_pixel(MODE_REF, 8'd255, 1'b1, 1'b0);
    // Exact match at offset zero
    push_pixel(MODE_WIN, 8'd0,   1'b0, 1'b0);
    push_pixel(MODE_WIN, 8'd255, 1'b0, 1'b0);
    push_pixel(MODE_WIN, 8'd0,   1'b1, 1'b0);
    // Exact match at offset one, full-scale miss at zero
    push_pixel(MODE_WIN, 8'd255, 1'b0, 1'b0);
    push_pixel(MODE_WIN, 8'd0,   1'b0, 1'b0);
    push_pixel(MODE_WIN, 8'd255, 1'b1, 1'b0);
    // Flat window: both offsets tie, the lower one wins
    push_pixel(MODE_WIN, 8'd9,   1'b0, 1'b0);
    push_pixel(MODE_WIN, 8'd9,   1'b0, 1'b0);
    push_pixel(MODE_WIN, 8'd9,   1'b1, 1'b0);
    // Window one pixel short
    push_pixel(MODE_WIN, 8'd0,   1'b0, 1'b0);
    push_pixel(MODE_WIN, 8'd255, 1'b1, 1'b0);
    // New reference run after a closed one, then one that appends before closing
    push_pixel(MODE_REF, 8'd255, 1'b0, 1'b0);
    push_pixel(MODE_REF, 8'd0,   1'b1, 1'b0);
    push_pixel(MODE_REF, 8'd7,   1'b0, 1'b0);
    push_pixel(MODE_REF, 8'd7,   1'b0, 1'b0);
    push_pixel(MODE_REF, 8'd7,   1'b1, 1'b0);
    // Longer window than needed: the extra pixel takes no part
    push_pixel(MODE_WIN, 8'd7,   1'b0, 1'b0);
    push_pixel(MODE_WIN, 8'd7,   1'b0, 1'b0);
    push_pixel(MODE_WIN, 8'd0,   1'b0, 1'b0);
    push_pixel(MODE_WIN, 8'd200, 1'b1, 1'b1);

    for (p = 0; p < N_PHASES; p++) begin
      wait_drained();
      write_reg(REG_SEG_WIDTH, seg_set[p]);
      write_reg(REG_SEARCH_RANGE, range_set[p]);
      if (p == 4) write_reg(REG_UNUSED, 7'h7F);
      if (p == N_PHASES - 1) begin
        // No idling in the closing phase
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end else begin
        send_idle_pct = 25 * $urandom_range(0, 2);
        recv_idle_pct = 25 * $urandom_range(0, 2);
      end
      gen_phase(PHASE_ITEMS);
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (fail_cnt == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // Pixel driver: predict on every transfer, then present the next queued pixel
  // unless an idle burst or a drain hold keeps valid low.
  always @(posedge clk_i) begin
    logic      next_valid;
    pix_item_t nxt;
    if (rst_ni) begin
      next_valid = in_valid;
      if (in_valid && !in_stall_o) begin
        match_pixel(in_mode, in_pixel, in_last);
        next_valid = 1'b0;
      end
      if (!next_valid) begin
        if (send_gap > 0) begin
          send_gap--;
        end else if (pixel_q.size() != 0 &&
                     !(pixel_q[0].hold && exp_match_q.size() != 0)) begin
          if (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct) begin
            send_gap = $urandom_range(0, 9);
          end else begin
            nxt        = pixel_q.pop_front();
            in_mode    <= nxt.mode;
            in_pixel   <= nxt.pixel;
            in_last    <= nxt.last;
            next_valid = 1'b1;
          end
        end
      end
      in_valid <= next_valid;
    end
  end

  // Result monitor: compare each transfer with the oldest expected match, and
  // stall in random bursts.
  always @(posedge clk_i) begin
    match_t exp_m;
    if (rst_ni) begin
      if (out_valid_o && !out_stall) begin
        if (exp_match_q.size() == 0) begin
          $error("result with no match expected: offset %0d cost %0d status %0d",
                 out_best_offset_o, out_min_cost_o, out_status_o);
          fail_cnt++;
        end else begin
          exp_m = exp_match_q.pop_front();
          if (out_best_offset_o !== exp_m.best_offset) begin
            $error("best_offset: expected %0d, actual %0d", exp_m.best_offset,
                   out_best_offset_o);
            fail_cnt++;
          end
          if (out_min_cost_o !== exp_m.min_cost) begin
            $error("min_cost: expected %0d, actual %0d", exp_m.min_cost, out_min_cost_o);
            fail_cnt++;
          end
          if (out_status_o !== exp_m.status) begin
            $error("status: expected %0d, actual %0d", exp_m.status, out_status_o);
            fail_cnt++;
          end
        end
      end
      if (recv_gap > 0) begin
        recv_gap--;
        out_stall <= 1'b1;
      end else if (recv_idle_pct != 0 && $urandom_range(0, 99) < recv_idle_pct) begin
        recv_gap  = $urandom_range(0, 9);
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Watchdog: any transfer on any channel restarts the count
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid && !in_stall_o) || (out_valid_o && !out_stall) ||
          (cfg_valid && cfg_ready_o)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
          $display("Regression FAIL");
          $finish;
        end
      end
    end
  end

endmodule
